// File: sv/ctts_pkg.sv
package ctts_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int TIME_BITS_DEF  = 16;
	localparam int MAX_RESULTS    = 8;
	localparam int HANDLE_W       = 16;
	localparam int PEND_W         = 8;
	localparam logic [PEND_W-1:0] PEND_MAX = '1;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_ADD  = 2'd1,
		ACT_DEL  = 2'd2,
		ACT_DISP = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE  = 3'd0,
		ST_ADDED = 3'd1,
		ST_FULL  = 3'd2,
		ST_RUN   = 3'd3,
		ST_IDLE  = 3'd4
	} status_t;

endpackage

// File: sv/cooperative_task_tick_scheduler.sv
// Add and delete: one result in the cycle after the beat is taken, busy stays low.
// Tick and dispatch: one pass of the slot table through one read port and one write port;
// busy is high for the whole pass and drops as the final result is presented.
// Dispatch results stream out during the pass, at most one per cycle; the receiver cannot stall.
// Reset clears the slot valid bits, the fill count and the sequencer; slot contents
// are not reset, an invalid slot reads as empty.
module cooperative_task_tick_scheduler #(
	parameter int SLOT_COUNT = ctts_pkg::SLOT_COUNT_DEF,
	parameter int TIME_BITS  = ctts_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] task_handle,
	input  logic [15:0] delay_ticks,
	input  logic [15:0] period_ticks,
	input  logic [2:0]  slot_number,
	output logic        valid,
	output logic [2:0]  status,
	output logic [2:0]  slot,
	output logic [15:0] run_handle,
	output logic        last
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int UW = $clog2(SLOT_COUNT + 1);
	localparam int SW = (IW > 3) ? IW : 3;
	localparam int NW = $clog2(ctts_pkg::MAX_RESULTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	typedef struct packed {
		logic [ctts_pkg::HANDLE_W-1:0] handle;
		logic [TIME_BITS-1:0]          delay;
		logic [TIME_BITS-1:0]          period;
		logic [ctts_pkg::PEND_W-1:0]   pend;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} state_t;

	entry_t mem [SLOT_COUNT];
	entry_t rd_s1;
	logic   rdv_s1;
	logic   p_s1;
	logic [IW-1:0] pidx_s1;

	state_t state_q;
	logic [IW-1:0] idx_q;
	logic          rd_go_q;
	logic          disp_q;
	logic [SLOT_COUNT-1:0] vld_q;
	logic [UW-1:0] used_q;
	logic [NW-1:0] n_q;
	logic          hold_v_q;
	logic [IW-1:0] hold_idx_q;
	logic [15:0]   hold_handle_q;

	logic        valid_q;
	logic [2:0]  status_q;
	logic [2:0]  slot_q;
	logic [15:0] handle_q;
	logic        last_q;

	entry_t cur;
	entry_t nxt;
	logic   accept;
	logic   add_go;
	logic   del_go;
	logic   tick_we;
	logic   disp_hit;
	logic   one_shot;
	logic   we;
	logic [IW-1:0] waddr;
	entry_t wdata;
	logic [SW-1:0] add_slot;
	logic [SW-1:0] hold_slot;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign valid      = valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign run_handle = handle_q;
	assign last       = last_q;

	assign add_go = accept && (action == ctts_pkg::ACT_ADD) && (used_q < UW'(SLOT_COUNT));
	assign del_go = accept && (action == ctts_pkg::ACT_DEL)
		&& ({29'd0, slot_number} < 32'(SLOT_COUNT));
	assign add_slot  = SW'(used_q[IW-1:0]);
	assign hold_slot = SW'(hold_idx_q);

	// per-slot update for the shared pass
	always_comb begin
		cur = rdv_s1 ? rd_s1 : '0;
		nxt = cur;
		one_shot = (cur.period == '0);
		if (!disp_q) begin
			if (cur.delay == '0) begin
				if (cur.pend != ctts_pkg::PEND_MAX) begin
					nxt.pend = cur.pend + 1'b1;
				end
				if (!one_shot) begin
					nxt.delay = cur.period;
				end
			end else begin
				nxt.delay = cur.delay - 1'b1;
			end
		end else begin
			nxt.pend = cur.pend - 1'b1;
		end
		tick_we  = p_s1 && !disp_q && (cur.handle != '0);
		disp_hit = p_s1 && disp_q && (cur.pend != '0) && (n_q < NW'(ctts_pkg::MAX_RESULTS));
	end

	always_comb begin
		we    = 1'b0;
		waddr = pidx_s1;
		wdata = nxt;
		if (add_go) begin
			we    = 1'b1;
			waddr = used_q[IW-1:0];
			wdata = '{handle: task_handle, delay: TIME_BITS'(delay_ticks),
				period: TIME_BITS'(period_ticks), pend: '0};
		end else if (tick_we || (disp_hit && !one_shot)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			idx_q         <= '0;
			rd_go_q       <= 1'b0;
			disp_q        <= 1'b0;
			vld_q         <= '0;
			used_q        <= '0;
			n_q           <= '0;
			hold_v_q      <= 1'b0;
			hold_idx_q    <= '0;
			hold_handle_q <= '0;
			p_s1          <= 1'b0;
			pidx_s1       <= '0;
			rdv_s1        <= 1'b0;
			valid_q       <= 1'b0;
			status_q      <= ctts_pkg::ST_DONE;
			slot_q        <= '0;
			handle_q      <= '0;
			last_q        <= 1'b0;
		end else begin
			valid_q  <= 1'b0;
			status_q <= ctts_pkg::ST_DONE;
			slot_q   <= '0;
			handle_q <= '0;
			last_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					p_s1 <= 1'b0;
					if (accept) begin
						idx_q    <= '0;
						n_q      <= '0;
						hold_v_q <= 1'b0;
						case (ctts_pkg::action_t'(action))
							ctts_pkg::ACT_TICK, ctts_pkg::ACT_DISP: begin
								state_q <= S_SCAN;
								rd_go_q <= 1'b1;
								disp_q  <= (action == ctts_pkg::ACT_DISP);
							end
							ctts_pkg::ACT_ADD: begin
								valid_q <= 1'b1;
								last_q  <= 1'b1;
								if (add_go) begin
									vld_q[used_q[IW-1:0]] <= 1'b1;
									used_q   <= used_q + 1'b1;
									status_q <= ctts_pkg::ST_ADDED;
									slot_q   <= add_slot[2:0];
								end else begin
									status_q <= ctts_pkg::ST_FULL;
								end
							end
							ctts_pkg::ACT_DEL: begin
								valid_q <= 1'b1;
								last_q  <= 1'b1;
								if (del_go) begin
									vld_q[IW'(slot_number)] <= 1'b0;
								end
							end
							default: begin
								valid_q <= 1'b1;
								last_q  <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue the read for the next slot
					if (rd_go_q) begin
						p_s1    <= 1'b1;
						pidx_s1 <= idx_q;
						rdv_s1  <= vld_q[idx_q];
						if (idx_q == LAST_IDX) begin
							rd_go_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						p_s1 <= 1'b0;
					end
					// hold one run result back so the final one can carry last
					if (disp_hit) begin
						if (one_shot) begin
							vld_q[pidx_s1] <= 1'b0;
						end
						if (hold_v_q) begin
							valid_q  <= 1'b1;
							status_q <= ctts_pkg::ST_RUN;
							slot_q   <= hold_slot[2:0];
							handle_q <= hold_handle_q;
						end
						hold_v_q      <= 1'b1;
						hold_idx_q    <= pidx_s1;
						hold_handle_q <= cur.handle;
						n_q           <= n_q + 1'b1;
					end
					if (p_s1 && (pidx_s1 == LAST_IDX)) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					p_s1    <= 1'b0;
					valid_q <= 1'b1;
					last_q  <= 1'b1;
					if (disp_q) begin
						if (hold_v_q) begin
							status_q <= ctts_pkg::ST_RUN;
							slot_q   <= hold_slot[2:0];
							handle_q <= hold_handle_q;
						end else begin
							status_q <= ctts_pkg::ST_IDLE;
						end
					end
					hold_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last && !accept) |=> !valid)
		else $error("result after last without a new beat");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(ctts_pkg::MAX_RESULTS))
		else $error("dispatch result count over limit");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (!rd_go_q && !p_s1))
		else $error("slot pass active while not busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(SLOT_COUNT))
		else $error("slot fill count over table size");

endmodule
